// ===== rtl/core/cmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mailbox bridge package
// Beat types, operation codes, window offsets and host addresses shared by
// the bridge core and its stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cmb_pkg;

    typedef enum logic [2:0] {
        OP_COP_IDLE   = 3'd0,
        OP_COP_READ   = 3'd1,
        OP_COP_WRITE  = 3'd2,
        OP_HOST_READ  = 3'd3,
        OP_HOST_WRITE = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  status_bits;
        logic [23:0] timer_value;
        logic        core_reset;
    } rsp_t;

    localparam int unsigned DelayWidth = 17;
    localparam int unsigned TimerWidth = 24;

    localparam logic [DelayWidth-1:0] READY_DELAY_RESET = 17'd65536;

    // Coprocessor window offsets.
    localparam logic [5:0] COP_TO_HOST   = 6'h00;
    localparam logic [5:0] COP_MAILBOX   = 6'h10;
    localparam logic [5:0] COP_SIGNAL    = 6'h10;
    localparam logic [5:0] COP_STATUS    = 6'h20;
    localparam logic [5:0] COP_LATCH_LO  = 6'h20;
    localparam logic [5:0] COP_LATCH_MID = 6'h24;
    localparam logic [5:0] COP_LATCH_HI  = 6'h28;
    localparam logic [5:0] COP_TIMER_GO  = 6'h2c;

    // Host addresses after masking.
    localparam logic [15:0] HOST_ADDR_MASK = 16'hff06;
    localparam logic [15:0] HOST_DATA      = 16'h3800;
    localparam logic [15:0] HOST_SIGNAL    = 16'h3802;
    localparam logic [15:0] HOST_STATUS    = 16'h3804;

    function automatic logic [7:0] status_byte(input logic to_host_full,
                                               input logic signal_flag,
                                               input logic to_cop_full,
                                               input logic ready_flag);
        status_byte = {ready_flag, 3'b000, to_cop_full, signal_flag, 1'b0, to_host_full};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cmb_in_stage.sv =====
// ----------------------------------------------------------------------------
// Command input register
// Holds one command beat until the bridge takes it; refills in the same
// cycle so that a beat can enter on every clock while the bridge keeps taking them.
// ----------------------------------------------------------------------------
`default_nettype none

module cmb_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire cmb_pkg::cmd_t cmd,
    input  wire logic          take,
    output logic               item_valid,
    output cmb_pkg::cmd_t      item
);

    logic          valid_reg;
    logic          valid_next;
    cmb_pkg::cmd_t item_reg;

    assign cmd_ready  = !valid_reg || take;
    assign valid_next = (valid_reg && !take) || cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cmb_bridge_regs.sv =====
// ----------------------------------------------------------------------------
// Bridge registers and access decode
// Mailboxes, signal flag, timer latch, countdown and ready sequencing; works
// out the result of the held command and commits the new state when it moves.
// ----------------------------------------------------------------------------
`default_nettype none

module cmb_bridge_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [cmb_pkg::DelayWidth-1:0]    cfg_wdata,
    input  wire logic                              fire,
    input  wire cmb_pkg::cmd_t                     item,
    output cmb_pkg::rsp_t                          result
);

    logic [cmb_pkg::DelayWidth-1:0] ready_delay_reg;
    logic [7:0]                     to_cop_byte_reg;
    logic                           to_cop_full_reg;
    logic [7:0]                     to_host_byte_reg;
    logic                           to_host_full_reg;
    logic                           signal_flag_reg;
    logic [cmb_pkg::TimerWidth-1:0] latch_value_reg;
    logic [cmb_pkg::TimerWidth-1:0] countdown_reg;
    logic                           reset_held_reg;
    logic                           ready_flag_reg;
    logic [cmb_pkg::DelayWidth-1:0] boot_steps_reg;

    logic [7:0]                     to_cop_byte_next;
    logic                           to_cop_full_next;
    logic [7:0]                     to_host_byte_next;
    logic                           to_host_full_next;
    logic                           signal_flag_next;
    logic [cmb_pkg::TimerWidth-1:0] latch_value_next;
    logic [cmb_pkg::TimerWidth-1:0] countdown_next;
    logic                           reset_held_next;
    logic                           ready_flag_next;
    logic [cmb_pkg::DelayWidth-1:0] boot_steps_next;
    logic [7:0]                     read_data;
    logic                           pulse;

    always_comb
    begin
        logic [5:0]  offset;
        logic [15:0] host_addr;

        offset            = item.address[5:0];
        host_addr         = item.address & cmb_pkg::HOST_ADDR_MASK;
        to_cop_byte_next  = to_cop_byte_reg;
        to_cop_full_next  = to_cop_full_reg;
        to_host_byte_next = to_host_byte_reg;
        to_host_full_next = to_host_full_reg;
        signal_flag_next  = signal_flag_reg;
        latch_value_next  = latch_value_reg;
        countdown_next    = countdown_reg;
        reset_held_next   = reset_held_reg;
        ready_flag_next   = ready_flag_reg;
        boot_steps_next   = boot_steps_reg;
        read_data         = 8'h00;
        pulse             = 1'b0;

        // Every coprocessor operation counts one step before its access.
        if (item.operation == cmb_pkg::OP_COP_IDLE || item.operation == cmb_pkg::OP_COP_READ
            || item.operation == cmb_pkg::OP_COP_WRITE)
        begin
            if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - 1'b1;
            end
            if (!reset_held_reg && !ready_flag_reg)
            begin
                boot_steps_next = boot_steps_reg + 1'b1;
                if (boot_steps_next >= ready_delay_reg)
                begin
                    ready_flag_next = 1'b1;
                end
            end
        end

        unique case (item.operation)
            cmb_pkg::OP_COP_READ:
            begin
                if (offset == cmb_pkg::COP_MAILBOX)
                begin
                    if (to_cop_full_reg)
                    begin
                        to_cop_full_next = 1'b0;
                        read_data        = to_cop_byte_reg;
                    end
                end
                else if (offset == cmb_pkg::COP_STATUS)
                begin
                    read_data = cmb_pkg::status_byte(to_host_full_reg, signal_flag_reg,
                                                     to_cop_full_reg, ready_flag_next);
                end
            end
            cmb_pkg::OP_COP_WRITE:
            begin
                unique case (offset)
                    cmb_pkg::COP_TO_HOST:
                    begin
                        to_host_full_next = 1'b1;
                        to_host_byte_next = item.data;
                    end
                    cmb_pkg::COP_SIGNAL:    signal_flag_next = 1'b1;
                    cmb_pkg::COP_LATCH_LO:  latch_value_next[7:0] = item.data;
                    cmb_pkg::COP_LATCH_MID: latch_value_next[15:8] = item.data;
                    cmb_pkg::COP_LATCH_HI:  latch_value_next[23:16] = item.data;
                    cmb_pkg::COP_TIMER_GO:  countdown_next = latch_value_reg;
                    default:
                    begin
                    end
                endcase
            end
            cmb_pkg::OP_HOST_READ:
            begin
                if (host_addr == cmb_pkg::HOST_DATA)
                begin
                    if (to_host_full_reg)
                    begin
                        to_host_full_next = 1'b0;
                        read_data         = to_host_byte_reg;
                    end
                end
                else if (host_addr == cmb_pkg::HOST_SIGNAL)
                begin
                    signal_flag_next = 1'b0;
                end
                else if (host_addr == cmb_pkg::HOST_STATUS)
                begin
                    read_data = cmb_pkg::status_byte(to_host_full_reg, signal_flag_reg,
                                                     to_cop_full_reg, ready_flag_reg);
                end
            end
            cmb_pkg::OP_HOST_WRITE:
            begin
                if (host_addr == cmb_pkg::HOST_SIGNAL)
                begin
                    to_cop_full_next = 1'b1;
                    to_cop_byte_next = item.data;
                end
                else if (host_addr == cmb_pkg::HOST_STATUS)
                begin
                    if (!reset_held_reg && item.data[0])
                    begin
                        ready_flag_next   = 1'b0;
                        signal_flag_next  = 1'b0;
                        countdown_next    = '0;
                        latch_value_next  = '0;
                        to_cop_full_next  = 1'b0;
                        to_host_full_next = 1'b0;
                        boot_steps_next   = '0;
                        pulse             = 1'b1;
                    end
                    reset_held_next = item.data[0];
                end
            end
            default:
            begin
            end
        endcase

        result.read_data   = read_data;
        result.status_bits = cmb_pkg::status_byte(to_host_full_next, signal_flag_next,
                                                  to_cop_full_next, ready_flag_next);
        result.timer_value = countdown_next;
        result.core_reset  = pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_delay_reg  <= cmb_pkg::READY_DELAY_RESET;
            to_cop_byte_reg  <= 8'h00;
            to_cop_full_reg  <= 1'b0;
            to_host_byte_reg <= 8'h00;
            to_host_full_reg <= 1'b0;
            signal_flag_reg  <= 1'b0;
            latch_value_reg  <= '0;
            countdown_reg    <= '0;
            reset_held_reg   <= 1'b0;
            ready_flag_reg   <= 1'b0;
            boot_steps_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ready_delay_reg <= cfg_wdata;
            end
            if (fire)
            begin
                to_cop_byte_reg  <= to_cop_byte_next;
                to_cop_full_reg  <= to_cop_full_next;
                to_host_byte_reg <= to_host_byte_next;
                to_host_full_reg <= to_host_full_next;
                signal_flag_reg  <= signal_flag_next;
                latch_value_reg  <= latch_value_next;
                countdown_reg    <= countdown_next;
                reset_held_reg   <= reset_held_next;
                ready_flag_reg   <= ready_flag_next;
                boot_steps_reg   <= boot_steps_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cmb_out_stage.sv =====
// ----------------------------------------------------------------------------
// Response output register
// Holds one response beat until it is taken and reloads in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmb_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire cmb_pkg::rsp_t result,
    output logic               can_load,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output cmb_pkg::rsp_t      rsp
);

    logic          valid_reg;
    cmb_pkg::rsp_t rsp_reg;

    assign can_load = !valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (can_load)
            begin
                valid_reg <= load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/coprocessor_mailbox_bridge_core.sv =====
// ----------------------------------------------------------------------------
// Coprocessor mailbox bridge core
// Path: a command beat is registered in the input stage, and its response beat in the output stage.
// Throughput: one beat per cycle while the response side keeps taking beats.
// Reset (async, rst_n low): all flags, bytes and timers clear; ready_delay = 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module coprocessor_mailbox_bridge_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  wire cmb_pkg::cmd_t                  cmd,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output cmb_pkg::rsp_t                       rsp,
    input  wire logic                           cfg_we,
    input  wire logic [cmb_pkg::DelayWidth-1:0] cfg_wdata
);

    logic          item_valid;
    cmb_pkg::cmd_t item;
    cmb_pkg::rsp_t result;
    logic          can_load;
    logic          fire;

    assign fire = item_valid && can_load;

    cmb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    cmb_bridge_regs u_bridge_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    cmb_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .can_load  (can_load),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // Input stalls only when both registers hold beats and the response is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (item_valid && rsp_valid && !rsp_ready))
        else $error("command stalled without a blocked response");

    // A core reset response reports cleared status bits, timer value and read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.core_reset) |->
            (rsp.status_bits == 8'h00 && rsp.timer_value == '0 && rsp.read_data == 8'h00))
        else $error("core reset response shows uncleared bridge state");

    // Unused status positions stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.status_bits & 8'h72) == 8'h00))
        else $error("reserved status bits set");

    // A moved command always lands in the response register.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid)
        else $error("response beat lost after command moved");
`endif

endmodule

`default_nettype wire
